// ===== rtl/brte_pkg.sv =====
// ----------------------------------------------------------------------------
// brte_pkg
// Shared widths, limits and defaults for the binary row transition extractor.
// ----------------------------------------------------------------------------
package brte_pkg;

    // Field widths
    localparam int PIX_W  = 8;   // pixels per input byte
    localparam int COL_W  = 8;   // transition column / marker value
    localparam int IDX_W  = 13;  // edge list index
    localparam int ROW_W  = 6;   // row number
    localparam int BYTE_W = 4;   // byte position within a row
    localparam int OFF_W  = 3;   // pixel offset within a byte

    // Stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    // Codes and limits
    localparam logic [COL_W-1:0] ROW_END_MARKER = 8'hFF;
    localparam logic [IDX_W-1:0] IDX_MAX        = {IDX_W{1'b1}};

    // Default geometry
    localparam int DEF_BYTES_PER_ROW  = 10;
    localparam int DEF_ROWS_PER_FRAME = 60;

endpackage

// ===== rtl/binary_row_transition_extractor.sv =====
// ----------------------------------------------------------------------------
// binary_row_transition_extractor
// Turns a packed 1-bit-per-pixel frame into a list of pixel transition
// columns, one row-end marker per row.
//
//  channel   | dir | tdata                              | tuser / tlast
//  ----------+-----+------------------------------------+------------------------
//  s_axis    | in  | pixel_byte                         | tuser: frame_start
//  m_axis    | out | entry_value, list_index, row_number| tuser: first_of_row,
//            |     |                                    | row_end; tlast: last_of_run
//
//  An input byte causes 0..9 results: one per pixel transition plus the
//  row-end marker on the last byte of a row; a byte with no result is
//  still accepted but leaves nothing to emit.
//  The work register emits one result per cycle into the output register while m_axis is not stalled;
//  the next byte is taken in the cycle the last result leaves.
//  Reset clears the row, list and pixel state and empties both registers.
//  A stall on m_axis holds the output beat and, once the work register is
//  loaded, holds off s_axis.
// ----------------------------------------------------------------------------
module binary_row_transition_extractor
    import brte_pkg::*;
#(
    parameter int BYTES_PER_ROW  = DEF_BYTES_PER_ROW,   // 1..16
    parameter int ROWS_PER_FRAME = DEF_ROWS_PER_FRAME   // 1..64
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel_byte
    input  logic                   s_axis_tuser,   // [0] frame_start

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] entry_value,
                                                   // [20:8] list_index,
                                                   // [26:21] row_number,
                                                   // [31:27] zero
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] first_of_row, [1] row_end
    output logic                   m_axis_tlast    // last_of_run
);

    localparam logic [BYTE_W:0] BPR = (BYTE_W+1)'(BYTES_PER_ROW);
    localparam logic [ROW_W:0]  RPF = (ROW_W+1)'(ROWS_PER_FRAME);

    // Row and list state
    logic              prev_pix_reg,  prev_pix_next;
    logic [BYTE_W-1:0] byte_pos_reg,  byte_pos_next;
    logic [ROW_W-1:0]  row_reg,       row_next;
    logic [IDX_W-1:0]  edge_cnt_reg,  edge_cnt_next;
    logic              has_edge_reg,  has_edge_next;

    // Work register: results still to emit for the current byte
    logic [PIX_W-1:0]  work_mask_reg,   work_mask_next;
    logic              work_marker_reg, work_marker_next;
    logic [BYTE_W-1:0] work_byte_reg,   work_byte_next;
    logic [ROW_W-1:0]  work_row_reg,    work_row_next;
    logic [IDX_W-1:0]  work_idx_reg,    work_idx_next;
    logic              work_first_reg,  work_first_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [COL_W-1:0]  out_value_reg, out_value_next;
    logic [IDX_W-1:0]  out_idx_reg,   out_idx_next;
    logic [ROW_W-1:0]  out_row_reg,   out_row_next;
    logic              out_first_reg, out_first_next;
    logic              out_end_reg,   out_end_next;
    logic              out_last_reg,  out_last_next;

    // Input decode
    logic [PIX_W-1:0]  pix;
    logic              start;
    logic              cur_prev;
    logic [BYTE_W-1:0] cur_byte;
    logic [BYTE_W-1:0] inc_byte;
    logic [ROW_W-1:0]  cur_row;
    logic [IDX_W-1:0]  cur_cnt;
    logic              cur_has;
    logic [PIX_W-1:0]  trans_mask;
    logic              row_done;
    logic [3:0]        n_results;
    logic [IDX_W:0]    cnt_sum;
    logic [ROW_W:0]    row_inc;

    // Emission
    logic              busy;
    logic              emit;
    logic              emit_edge;
    logic              emit_last;
    logic [OFF_W-1:0]  sel;
    logic [PIX_W-1:0]  mask_after;
    logic              accept;

    assign pix   = s_axis_tdata[PIX_W-1:0];
    assign start = s_axis_tuser;

    // Find transitions of the incoming byte, column order (bit 7 first)
    always_comb
    begin
        cur_prev = start ? 1'b0 : prev_pix_reg;
        cur_byte = start ? '0 : byte_pos_reg;
        cur_row  = start ? '0 : row_reg;
        cur_cnt  = start ? '0 : edge_cnt_reg;
        cur_has  = start ? 1'b0 : has_edge_reg;

        trans_mask[0] = pix[PIX_W-1] ^ cur_prev;
        for (int i = 1; i < PIX_W; i++)
        begin
            trans_mask[i] = pix[PIX_W-1-i] ^ pix[PIX_W-i];
        end

        inc_byte = cur_byte + 1'b1;
        row_done = ({1'b0, inc_byte} >= BPR) || (inc_byte == '0);

        n_results = {3'b000, row_done};
        for (int i = 0; i < PIX_W; i++)
        begin
            n_results = n_results + {3'b000, trans_mask[i]};
        end

        cnt_sum = {1'b0, cur_cnt} + {{(IDX_W-3){1'b0}}, n_results};
        row_inc = {1'b0, cur_row} + 1'b1;
    end

    // Pick the leftmost pending transition
    always_comb
    begin
        sel = '0;
        for (int i = PIX_W-1; i >= 0; i--)
        begin
            if (work_mask_reg[i])
            begin
                sel = OFF_W'(i);
            end
        end
        mask_after = work_mask_reg & ~(PIX_W'(1) << sel);
        emit_edge  = (work_mask_reg != '0);
        emit_last  = emit_edge ? ((mask_after == '0) && !work_marker_reg) : 1'b1;
        busy       = emit_edge || work_marker_reg;
        emit       = busy && (!out_valid_reg || m_axis_tready);
    end

    assign s_axis_tready = !busy || (emit && emit_last);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Advance row and list state on each accepted byte
    always_comb
    begin
        prev_pix_next = prev_pix_reg;
        byte_pos_next = byte_pos_reg;
        row_next      = row_reg;
        edge_cnt_next = edge_cnt_reg;
        has_edge_next = has_edge_reg;
        if (accept)
        begin
            edge_cnt_next = (cnt_sum > {1'b0, IDX_MAX}) ? IDX_MAX : cnt_sum[IDX_W-1:0];
            if (row_done)
            begin
                prev_pix_next = 1'b0;
                byte_pos_next = '0;
                has_edge_next = 1'b0;
                row_next      = (row_inc >= RPF) ? '0 : row_inc[ROW_W-1:0];
            end
            else
            begin
                prev_pix_next = pix[0];
                byte_pos_next = inc_byte;
                has_edge_next = cur_has || (trans_mask != '0);
                row_next      = cur_row;
            end
        end
    end

    // Load the work register on accept, drain it one result per beat
    always_comb
    begin
        work_mask_next   = work_mask_reg;
        work_marker_next = work_marker_reg;
        work_byte_next   = work_byte_reg;
        work_row_next    = work_row_reg;
        work_idx_next    = work_idx_reg;
        work_first_next  = work_first_reg;
        if (accept)
        begin
            work_mask_next   = trans_mask;
            work_marker_next = row_done;
            work_byte_next   = cur_byte;
            work_row_next    = cur_row;
            work_idx_next    = cur_cnt;
            work_first_next  = !cur_has;
        end
        else if (emit)
        begin
            work_idx_next = (work_idx_reg == IDX_MAX) ? IDX_MAX : work_idx_reg + 1'b1;
            if (emit_edge)
            begin
                work_mask_next  = mask_after;
                work_first_next = 1'b0;
            end
            else
            begin
                work_marker_next = 1'b0;
            end
        end
    end

    // Fill the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_idx_next   = out_idx_reg;
        out_row_next   = out_row_reg;
        out_first_next = out_first_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_value_next = emit_edge ? {1'b0, work_byte_reg, sel} : ROW_END_MARKER;
            out_idx_next   = work_idx_reg;
            out_row_next   = work_row_reg;
            out_first_next = emit_edge && work_first_reg;
            out_end_next   = !emit_edge;
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pix_reg    <= 1'b0;
            byte_pos_reg    <= '0;
            row_reg         <= '0;
            edge_cnt_reg    <= '0;
            has_edge_reg    <= 1'b0;
            work_mask_reg   <= '0;
            work_marker_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            prev_pix_reg    <= prev_pix_next;
            byte_pos_reg    <= byte_pos_next;
            row_reg         <= row_next;
            edge_cnt_reg    <= edge_cnt_next;
            has_edge_reg    <= has_edge_next;
            work_mask_reg   <= work_mask_next;
            work_marker_reg <= work_marker_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_byte_reg  <= work_byte_next;
        work_row_reg   <= work_row_next;
        work_idx_reg   <= work_idx_next;
        work_first_reg <= work_first_next;
        out_value_reg  <= out_value_next;
        out_idx_reg    <= out_idx_next;
        out_row_reg    <= out_row_next;
        out_first_reg  <= out_first_next;
        out_end_reg    <= out_end_next;
        out_last_reg   <= out_last_next;
    end

    // Drive the master side
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-COL_W-IDX_W-ROW_W){1'b0}},
                            out_row_reg, out_idx_reg, out_value_reg};
    assign m_axis_tuser  = {out_end_reg, out_first_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    // A loaded work register with a stalled output blocks new bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        busy && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while results are blocked");

    // A row-end marker always closes its byte's results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_last_reg && !out_first_reg)
        else $error("row-end marker not last or flagged first");

    // A taken beat that is not last is followed by another result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && m_axis_tready && !out_last_reg |=> out_valid_reg)
        else $error("gap inside a byte's results");

    // Consecutive results of one byte step the list index by one or saturate
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && m_axis_tready && !out_last_reg |=>
        (out_idx_reg == $past(out_idx_reg) + 1'b1) || (out_idx_reg == IDX_MAX))
        else $error("list index skipped within a byte");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of binary_row_transition_extractor. Pixel bytes go in on
// s_axis and each accepted beat runs through a local transition predictor.
// Every m_axis beat is checked field by field against the oldest predicted
// entry. The run opens with a short directed table. Random frames follow
// under several idle and stall mixes, including one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import brte_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int WATCHDOG_MAX = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int REPORT_MAX   = 10;
    localparam int BPR          = DEF_BYTES_PER_ROW;
    localparam int RPF          = DEF_ROWS_PER_FRAME;
    localparam int DIR_ROWS     = 25;

    // One predicted edge list entry
    typedef struct packed {
        logic [COL_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic [ROW_W-1:0] row;
        logic             first;
        logic             rend;
        logic             last;
    } edge_entry_t;

    // One directed stimulus row, with optional typed first entry
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             fs;
        logic             typed;
        logic [COL_W-1:0] t_value;
        logic [IDX_W-1:0] t_index;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    // Predictor state
    logic              prev_pix;
    logic [BYTE_W-1:0] byte_pos;
    logic [ROW_W-1:0]  row_cnt;
    logic [IDX_W-1:0]  edge_cnt;
    logic              row_edge;
    int                last_count;

    edge_entry_t edge_list_q [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    stim_row_t dir_tab [0:DIR_ROWS-1] = '{
        // empty row: nine silent bytes, then only the marker
        '{8'h00, 1'b1, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b1, ROW_END_MARKER, 13'd0},
        // row starting white, then whole-byte runs and alternating bytes
        '{8'hFF, 1'b0, 1'b1, 8'd0, 13'd1},
        '{8'hFF, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'hAA, 1'b0, 1'b1, 8'd24, 13'd3},
        '{8'h55, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h0F, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'hF0, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h80, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h01, 1'b0, 1'b0, 8'h00, 13'd0},
        // eight transitions plus the marker from one byte
        '{8'h55, 1'b0, 1'b0, 8'h00, 13'd0},
        // frame start in the middle of a stream
        '{8'hFF, 1'b1, 1'b1, 8'd0, 13'd0},
        '{8'h7F, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h00, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h81, 1'b0, 1'b0, 8'h00, 13'd0},
        '{8'h3C, 1'b0, 1'b0, 8'h00, 13'd0}
    };

    binary_row_transition_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] frame_start
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] entry_value, [20:8] list_index,
                                         // [26:21] row_number, [31:27] zero
        .m_axis_tuser  (m_axis_tuser),   // [0] first_of_row, [1] row_end
        .m_axis_tlast  (m_axis_tlast)    // last_of_run
    );

    // Free-running clock
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Append one entry and advance the saturating list index
    task automatic push_edge_entry(input logic [COL_W-1:0] value, input logic first,
                                   input logic rend);
        edge_entry_t e;
        e.value = value;
        e.index = edge_cnt;
        e.row   = row_cnt;
        e.first = first;
        e.rend  = rend;
        e.last  = 1'b0;
        edge_list_q.push_back(e);
        if (edge_cnt != IDX_MAX)
            edge_cnt = edge_cnt + 1'b1;
    endtask

    // Predict the entries one pixel byte causes
    task automatic predict_transitions(input logic [PIX_W-1:0] pix, input logic fs);
        int          base;
        int          col;
        logic        bitv;
        edge_entry_t e;
        base = edge_list_q.size();
        if (fs)
        begin
            prev_pix = 1'b0;
            byte_pos = '0;
            row_cnt  = '0;
            edge_cnt = '0;
            row_edge = 1'b0;
        end
        // walk pixels left to right, bit 7 first
        for (int b = PIX_W - 1; b >= 0; b--)
        begin
            bitv = pix[b];
            if (bitv != prev_pix)
            begin
                col = int'(byte_pos) * 8 + (7 - b);
                push_edge_entry(col[COL_W-1:0], ~row_edge, 1'b0);
                row_edge = 1'b1;
            end
            prev_pix = bitv;
        end
        // close the row on its last byte
        byte_pos = byte_pos + 1'b1;
        if (int'(byte_pos) >= BPR || byte_pos == '0)
        begin
            push_edge_entry(ROW_END_MARKER, 1'b0, 1'b1);
            byte_pos = '0;
            prev_pix = 1'b0;
            row_edge = 1'b0;
            if (int'(row_cnt) + 1 >= RPF)
                row_cnt = '0;
            else
                row_cnt = row_cnt + 1'b1;
        end
        last_count = edge_list_q.size() - base;
        if (last_count > 0)
        begin
            e = edge_list_q[$];
            e.last = 1'b1;
            edge_list_q[$] = e;
        end
    endtask

    // Offer one beat, with random idle cycles ahead of it
    task automatic send_pixel_byte(input logic [PIX_W-1:0] pix, input logic fs);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_transitions(pix, fs);
    endtask

    // Random frames: mostly whole rows, rare stray frame starts
    task automatic run_random_frames(input int count);
        logic [PIX_W-1:0] pix;
        logic             fs;
        for (int i = 0; i < count; i++)
        begin
            fs = (i == 0) || ($urandom_range(0, 99) < 2);
            case ($urandom_range(0, 5))
                0: pix = 8'h00;
                1: pix = 8'hFF;
                4: pix = 8'hFF >> $urandom_range(0, 7);
                5: pix = ~(8'hFF >> $urandom_range(1, 7));
                default: pix = PIX_W'($urandom);
            endcase
            send_pixel_byte(pix, fs);
        end
    endtask

    task automatic wait_list_empty();
        while (edge_list_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall, or a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check each output beat against the oldest predicted entry
    always @(posedge clk)
    begin
        edge_entry_t e;
        logic        bad;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (edge_list_q.size() == 0)
            begin
                errors = errors + 1;
                if (errors <= REPORT_MAX)
                    $display("%0t: unexpected beat tdata=%h tuser=%b tlast=%b",
                             $realtime, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            else
            begin
                e = edge_list_q.pop_front();
                bad = (m_axis_tdata[7:0] !== e.value) || (m_axis_tdata[20:8] !== e.index)
                    || (m_axis_tdata[26:21] !== e.row) || (m_axis_tdata[31:27] !== 5'd0)
                    || (m_axis_tuser[0] !== e.first) || (m_axis_tuser[1] !== e.rend)
                    || (m_axis_tlast !== e.last);
                if (bad)
                begin
                    errors = errors + 1;
                    // fields: value/index/row[/pad]/first,end,last
                    if (errors <= REPORT_MAX)
                        $display("%0t: mismatch exp %0d/%0d/%0d/%b%b%b got %0d/%0d/%0d/%h/%b%b%b",
                                 $realtime, e.value, e.index, e.row, e.first, e.rend,
                                 e.last, m_axis_tdata[7:0], m_axis_tdata[20:8],
                                 m_axis_tdata[26:21], m_axis_tdata[31:27],
                                 m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast);
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        edge_entry_t e;
        int          base;
        prev_pix = 1'b0;
        byte_pos = '0;
        row_cnt  = '0;
        edge_cnt = '0;
        row_edge = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, typed first entries override the prediction
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_pixel_byte(dir_tab[i].pix, dir_tab[i].fs);
            base = edge_list_q.size() - last_count;
            if (dir_tab[i].typed && last_count > 0)
            begin
                e = edge_list_q[base];
                e.value = dir_tab[i].t_value;
                e.index = dir_tab[i].t_index;
                edge_list_q[base] = e;
            end
        end

        // no idling, with one long receiver hold-off while bytes keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_reqs = hold_reqs + 1;
        run_random_frames(60);

        send_idle_pct  = 57;
        recv_stall_pct = 0;
        run_random_frames(60);

        send_idle_pct  = 0;
        recv_stall_pct = 57;
        run_random_frames(60);

        send_idle_pct  = 33;
        recv_stall_pct = 33;
        run_random_frames(60);

        s_axis_tvalid <= 1'b0;
        wait_list_empty();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
